// ===== hdl/tmmu_pkg.sv =====
// Package for the transposed matrix multiply unit: item codes, sequencer
// states, fixed-point widths and the control bundle handed to the MAC unit.
// No dependencies.
package tmmu_pkg;

  // item function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_APPLY = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // register select, taken from paddr[2]
  localparam logic REG_ROWS_USED = 1'b0;
  localparam logic REG_COLS_USED = 1'b1;

  localparam int CFG_W  = 7;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DRAIN,
    ST_READ
  } state_t;

  typedef struct packed {
    logic issue;   // operands at the MAC inputs are valid this cycle
    logic clear;   // treat the old accumulator as zero
  } mac_ctl_t;

endpackage

// ===== hdl/tmmu_mac.sv =====
// Shared two-stage multiply / saturating accumulate unit.
// Stage one registers the Q16.16 product, stage two adds and saturates.
// Depends on tmmu_pkg.
module tmmu_mac
  import tmmu_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] a_value,
  input  logic signed [VAL_W-1:0] b_value,
  input  logic signed [ACC_W-1:0] acc_in,
  input  logic [AW-1:0]           addr_in,
  output logic                    wr_en,
  output logic [AW-1:0]           wr_addr,
  output logic signed [ACC_W-1:0] wr_data
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     vld;
  logic [AW-1:0]            addr;
  logic [ACC_W:0]           sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_value * b_value;
    acc  <= ctl.clear ? '0 : acc_in;
    addr <= addr_in;
  end

  // 49-bit sum, overflow when the two top bits differ
  assign sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      wr_data = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      wr_data = sum[ACC_W-1:0];
    end
  end

  assign wr_en   = vld;
  assign wr_addr = addr;

endmodule

// ===== hdl/transposed_matrix_multiply_unit.sv =====
// Top level of the transposed matrix multiply unit, C = A^T * B by outer
// products. Holds the sequencer, row buffer, result memory and APB registers.
// Depends on tmmu_pkg and tmmu_mac.
//
//  channel   signals                                      direction
//  --------  -------------------------------------------  ---------
//  config    psel penable pwrite paddr pwdata prdata      APB slave
//  item in   start busy func row_index col_index          in
//            element_value first_row
//  result    done read_value index_error                  out, 1 cycle
//
// A load, an ignored item or an out-of-range read leaves busy low.
// An apply walks the active rows through the one shared MAC, one row per
// cycle; busy then stays high while the MAC pipeline drains (memory read,
// multiply, saturating add and write back).
// An in-range read holds busy for a registered memory read; done follows
// in the cycle after. Out-of-range reads give done on the next cycle.
// Reset (rst, synchronous) sets rows_used and cols_used to 64 and idles
// the sequencer; memories are not cleared. The receiver cannot stall: done
// marks read_value/index_error for exactly one cycle.
module transposed_matrix_multiply_unit
  import tmmu_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // items
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              func,
  input  logic [5:0]              row_index,
  input  logic [5:0]              col_index,
  input  logic signed [VAL_W-1:0] element_value,
  input  logic                    first_row,
  // results
  output logic                    done,
  output logic signed [ACC_W-1:0] read_value,
  output logic                    index_error
);

  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CLW  = $clog2(MAX_COLS + 1);
  localparam int AW_A = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW   = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  // configuration registers
  logic [CFG_W-1:0] rows_used;
  logic [CFG_W-1:0] cols_used;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= CFG_W'(64);
      cols_used <= CFG_W'(64);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROWS_USED: rows_used <= pwdata[CFG_W-1:0];
        REG_COLS_USED: cols_used <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS_USED: prdata = 32'(rows_used);
      REG_COLS_USED: prdata = 32'(cols_used);
      default:       prdata = '0;
    endcase
  end

  // active sizes, clamped to the storage
  logic [RW-1:0]  nr;
  logic [CLW-1:0] nc;
  logic           row_ok;
  logic           col_ok;

  always_comb begin
    nr = (11'(rows_used) < 11'(MAX_ROWS)) ? RW'(rows_used) : RW'(MAX_ROWS);
    nc = (11'(cols_used) < 11'(MAX_COLS)) ? CLW'(cols_used) : CLW'(MAX_COLS);
  end

  assign row_ok = 11'(row_index) < 11'(nr);
  assign col_ok = 11'(col_index) < 11'(nc);

  // sequencer state
  state_t                  state, state_next;
  logic                    accept;
  logic [RW-1:0]           i_cnt;
  logic [CW-1:0]           addr_run;
  logic signed [VAL_W-1:0] b_val;
  logic                    first_q;
  logic                    v1;        // memory read data valid for the MAC
  logic [CW-1:0]           addr1;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_APPLY && col_ok && nr != '0) begin
          state_next = ST_APPLY;
        end else if (accept && func == FUNC_READ && row_ok && col_ok) begin
          state_next = ST_READ;
        end
      end
      ST_APPLY: begin
        if (i_cnt == RW'(nr - RW'(1))) begin
          state_next = ST_DRAIN;
        end
      end
      // last write lands at the edge where v1 has already dropped
      ST_DRAIN: begin
        if (!v1) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // output / datapath control
  logic                    a_we;
  logic                    issue;
  logic [CW-1:0]           c_raddr;
  logic                    done_next;
  logic                    err_next;
  logic signed [ACC_W-1:0] c_rdata;
  logic signed [VAL_W-1:0] a_rdata;

  always_comb begin
    a_we      = 1'b0;
    issue     = 1'b0;
    done_next = 1'b0;
    err_next  = 1'b0;
    c_raddr   = CW'(32'(row_index) * 32'(MAX_COLS) + 32'(col_index));
    case (state)
      ST_IDLE: begin
        a_we = accept && func == FUNC_LOAD && row_ok;
        if (accept && func == FUNC_READ && !(row_ok && col_ok)) begin
          done_next = 1'b1;
          err_next  = 1'b1;
        end
      end
      ST_APPLY: begin
        issue   = 1'b1;
        c_raddr = addr_run;
      end
      ST_READ:  done_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      v1    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_cnt    <= '0;
      addr_run <= CW'(col_index);
      b_val    <= element_value;
      first_q  <= first_row;
    end else if (issue) begin
      i_cnt    <= i_cnt + RW'(1);
      addr_run <= addr_run + CW'(MAX_COLS);
    end
    addr1 <= addr_run;
    if (done_next) begin
      read_value  <= err_next ? '0 : c_rdata;
      index_error <= err_next;
    end
  end

  // row buffer: one write, one registered read
  logic signed [VAL_W-1:0] a_mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[AW_A'(row_index)] <= element_value;
    end
    a_rdata <= a_mem[AW_A'(i_cnt)];
  end

  // result store: one write, one registered read
  logic signed [ACC_W-1:0] c_mem [MAX_ROWS * MAX_COLS];
  logic                    c_we;
  logic [CW-1:0]           c_waddr;
  logic signed [ACC_W-1:0] c_wdata;

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_rdata <= c_mem[c_raddr];
  end

  mac_ctl_t mac_ctl;

  assign mac_ctl = '{issue: v1, clear: first_q};

  tmmu_mac #(
    .AW(CW)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .a_value (a_rdata),
    .b_value (b_val),
    .acc_in  (c_rdata),
    .addr_in (addr1),
    .wr_en   (c_we),
    .wr_addr (c_waddr),
    .wr_data (c_wdata)
  );

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |-> 11'(i_cnt) < 11'(nr))
    else $error("row counter beyond active rows");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    c_we |-> state == ST_DRAIN || state == ST_APPLY)
    else $error("result write outside an apply");

  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_READ |=> done || state == ST_READ)
    else $error("read item without answer path");

endmodule
